@@ rtl/rhps_pkg.sv @@
// ----------------------------------------------------------------------------
// rhps_pkg
// Shared constants, codes and command/status structs for the rolling hash
// pattern search block.
// ----------------------------------------------------------------------------
package rhps_pkg;

   localparam int PATTERN_MAX_DEF = 64;
   localparam int LEN_W           = 7;
   localparam int HASH_W          = 30;
   localparam int DIGIT_W         = 9;

   localparam logic [HASH_W-1:0]  HASH_MOD  = 30'd1000000007;
   localparam logic [DIGIT_W-1:0] HASH_BASE = 9'd257;
   localparam logic [3:0]         MUL_STEPS = 4'd9;

   // item function codes
   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_TEXT  = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   // operand set for the modular multiplier
   typedef enum logic [2:0] {
      MUL_SRC_PAT  = 3'd0,
      MUL_SRC_POW  = 3'd1,
      MUL_SRC_REM  = 3'd2,
      MUL_SRC_TEXT = 3'd3,
      MUL_SRC_ROLL = 3'd4
   } mul_src_type;

   typedef struct packed {
      logic        capture;
      logic        pat_write;
      logic        pat_first;
      logic        clear_text;
      logic        mul_start;
      mul_src_type mul_src;
      logic        mul_finish;
      logic        commit;
      logic        ver_start;
      logic        ver_step;
      logic        miss;
      logic        emit;
   } rhps_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       idx_ok;
      logic       idx_zero;
      logic       text_full;
      logic       mul_ready;
      logic       now_full;
      logic       hash_equal;
      logic       ver_done;
      logic       out_free;
   } rhps_sts_type;

endpackage

@@ rtl/rhps_ram.sv @@
// ----------------------------------------------------------------------------
// rhps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rhps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/rhps_ctrl.sv @@
// ----------------------------------------------------------------------------
// rhps_ctrl
// Sequencer: decodes each transaction and steps the datapath through hash
// update, ring commit, verification and result hand-off.
// ----------------------------------------------------------------------------
module rhps_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  rhps_pkg::rhps_sts_type sts,
   output rhps_pkg::rhps_cmd_type cmd
);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_DISPATCH  = 13'b0000000000010,
      ST_MUL_PAT   = 13'b0000000000100,
      ST_LOAD_POW  = 13'b0000000001000,
      ST_MUL_POW   = 13'b0000000010000,
      ST_LOAD_REM  = 13'b0000000100000,
      ST_MUL_REM   = 13'b0000001000000,
      ST_LOAD_ROLL = 13'b0000010000000,
      ST_MUL_TEXT  = 13'b0000100000000,
      ST_COMMIT    = 13'b0001000000000,
      ST_VERIFY    = 13'b0010000000000,
      ST_EMIT      = 13'b0100000000000,
      ST_SPARE     = 13'b1000000000000
   } rhps_state_type;

   rhps_state_type state_ff, state_in;

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.mul_src     = rhps_pkg::MUL_SRC_PAT;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_IDLE;
            case (sts.func)
               rhps_pkg::FUNC_LOAD: begin
                  if (sts.idx_ok) begin
                     cmd.pat_write = 1'b1;
                     if (sts.idx_zero) begin
                        cmd.pat_first = 1'b1;
                     end else begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_src   = rhps_pkg::MUL_SRC_PAT;
                        state_in      = ST_MUL_PAT;
                     end
                  end
               end
               rhps_pkg::FUNC_TEXT: begin
                  if (sts.text_full) begin
                     state_in = ST_LOAD_REM;
                  end else begin
                     cmd.mul_start = 1'b1;
                     cmd.mul_src   = rhps_pkg::MUL_SRC_TEXT;
                     state_in      = ST_MUL_TEXT;
                  end
               end
               rhps_pkg::FUNC_START: begin
                  cmd.clear_text = 1'b1;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MUL_PAT: begin
            if (sts.mul_ready) begin
               cmd.mul_finish = 1'b1;
               state_in       = ST_LOAD_POW;
            end
         end
         ST_LOAD_POW: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = rhps_pkg::MUL_SRC_POW;
            state_in      = ST_MUL_POW;
         end
         ST_MUL_POW: begin
            if (sts.mul_ready) begin
               cmd.mul_finish = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_LOAD_REM: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = rhps_pkg::MUL_SRC_REM;
            state_in      = ST_MUL_REM;
         end
         ST_MUL_REM: begin
            if (sts.mul_ready) begin
               cmd.mul_finish = 1'b1;
               state_in       = ST_LOAD_ROLL;
            end
         end
         ST_LOAD_ROLL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_src   = rhps_pkg::MUL_SRC_ROLL;
            state_in      = ST_MUL_TEXT;
         end
         ST_MUL_TEXT: begin
            if (sts.mul_ready) begin
               cmd.mul_finish = 1'b1;
               state_in       = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            if (!sts.now_full) begin
               state_in = ST_IDLE;
            end else if (sts.hash_equal) begin
               cmd.ver_start = 1'b1;
               state_in      = ST_VERIFY;
            end else begin
               cmd.miss = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_VERIFY: begin
            cmd.ver_step = 1'b1;
            if (sts.ver_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

@@ rtl/rhps_dp.sv @@
// ----------------------------------------------------------------------------
// rhps_dp
// Datapath: hash registers, bit-serial modular multiplier, pattern and window
// RAMs, verification walk and result register.
// ----------------------------------------------------------------------------
module rhps_dp #(
   parameter int PATTERN_MAX = rhps_pkg::PATTERN_MAX_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rhps_pkg::rhps_cmd_type cmd,
   output rhps_pkg::rhps_sts_type sts,
   input  logic [1:0]             req_func,
   input  logic [5:0]             req_index,
   input  logic [7:0]             req_byte_value,
   input  logic                   csr_we,
   input  logic [6:0]             csr_wdata,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_match_found,
   output logic [31:0]            rsp_match_position,
   output logic [29:0]            rsp_window_hash
);

   localparam int AW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int SW = AW + 9;
   localparam int HW = rhps_pkg::HASH_W;
   localparam int LW = rhps_pkg::LEN_W;
   localparam logic [HW:0] MOD_X = {1'b0, rhps_pkg::HASH_MOD};

   // control state
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [31:0]   count_ff, count_in;
   logic [HW-1:0] ph_ff, ph_in, rh_ff, rh_in, tp_ff, tp_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [LW-1:0] vissue_ff, vissue_in;
   logic          pend_ff, pend_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [1:0]    func_ff, func_in;
   logic [5:0]    idx_ff, idx_in;
   logic [7:0]    byte_ff, byte_in;
   rhps_pkg::mul_src_type src_ff, src_in;
   logic [HW-1:0] acc_ff, acc_in, ma_ff, ma_in;
   logic [8:0]    mm_ff, mm_in, mc_ff, mc_in;
   logic [AW-1:0] vring_ff, vring_in;
   logic          found_ff, found_in;
   logic          out_found_ff, out_found_in;
   logic [31:0]   out_pos_ff, out_pos_in;
   logic [HW-1:0] out_hash_ff, out_hash_in;

   logic [7:0]    ring_rdata, pat_rdata;
   logic [AW-1:0] ring_raddr, pat_raddr, idx_addr, ptr_next, oldest, vstart;
   logic [SW-1:0] vissue_wide, idx_wide;
   logic [8:0]    digit, old_digit;
   logic [HW:0]   dbl, dbl_red, add, add_red, fin, fin_red, sub, sub_red;
   logic [HW-1:0] fin_val, roll_a;
   logic [31:0]   count_next;

   function automatic logic [AW-1:0] ring_back(input logic [AW-1:0] p,
                                               input logic [LW-1:0] n);
      logic [SW-1:0] s;
      s = SW'(p) + SW'(PATTERN_MAX) - SW'(n);
      if (s >= SW'(PATTERN_MAX)) begin
         s = s - SW'(PATTERN_MAX);
      end
      return s[AW-1:0];
   endfunction

   assign digit     = {1'b0, byte_ff} + 9'd1;
   assign old_digit = {1'b0, ring_rdata} + 9'd1;
   assign ptr_next  = (ptr_ff == AW'(PATTERN_MAX - 1)) ? '0 : ptr_ff + AW'(1);
   assign oldest    = ring_back(ptr_ff, len_ff);
   assign vstart    = ring_back(ptr_next, len_ff);
   assign count_next = (count_ff == 32'hFFFF_FFFF) ? count_ff : count_ff + 32'd1;

   assign vissue_wide = SW'(vissue_ff);
   assign idx_wide    = SW'(idx_ff);
   assign pat_raddr   = vissue_wide[AW-1:0];
   assign idx_addr    = idx_wide[AW-1:0];
   assign ring_raddr  = cmd.ver_step ? vring_ff : oldest;

   // one multiplier step: double, reduce, conditionally add, reduce
   assign dbl     = {acc_ff, 1'b0};
   assign dbl_red = (dbl >= MOD_X) ? dbl - MOD_X : dbl;
   assign add     = dbl_red + {1'b0, ma_ff};
   assign add_red = mm_ff[8] ? ((add >= MOD_X) ? add - MOD_X : add) : dbl_red;
   assign fin     = {1'b0, acc_ff} + (HW + 1)'(mc_ff);
   assign fin_red = (fin >= MOD_X) ? fin - MOD_X : fin;
   assign fin_val = fin_red[HW-1:0];
   // window hash with the oldest byte taken out
   assign sub     = {1'b0, rh_ff} + (MOD_X - {1'b0, acc_ff});
   assign sub_red = (sub >= MOD_X) ? sub - MOD_X : sub;
   assign roll_a  = sub_red[HW-1:0];

   always_comb begin
      len_in       = len_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      ph_in        = ph_ff;
      rh_in        = rh_ff;
      tp_in        = tp_ff;
      cnt_in       = cnt_ff;
      vissue_in    = vissue_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      func_in      = func_ff;
      idx_in       = idx_ff;
      byte_in      = byte_ff;
      src_in       = src_ff;
      acc_in       = acc_ff;
      ma_in        = ma_ff;
      mm_in        = mm_ff;
      mc_in        = mc_ff;
      vring_in     = vring_ff;
      found_in     = found_ff;
      out_found_in = out_found_ff;
      out_pos_in   = out_pos_ff;
      out_hash_in  = out_hash_ff;

      if (csr_we) begin
         if (csr_wdata == '0) begin
            len_in = LW'(1);
         end else if (int'(csr_wdata) > PATTERN_MAX) begin
            len_in = LW'(PATTERN_MAX);
         end else begin
            len_in = csr_wdata;
         end
      end

      if (cmd.capture) begin
         func_in = req_func;
         idx_in  = req_index;
         byte_in = req_byte_value;
      end

      if (cmd.pat_first) begin
         ph_in = HW'(digit);
         tp_in = HW'(1);
      end

      if (cmd.clear_text) begin
         count_in = '0;
         rh_in    = '0;
         ptr_in   = '0;
      end

      if (cmd.mul_start) begin
         src_in = cmd.mul_src;
         cnt_in = rhps_pkg::MUL_STEPS;
         acc_in = '0;
         case (cmd.mul_src)
            rhps_pkg::MUL_SRC_PAT: begin
               ma_in = ph_ff;  mm_in = rhps_pkg::HASH_BASE; mc_in = digit;
            end
            rhps_pkg::MUL_SRC_POW: begin
               ma_in = tp_ff;  mm_in = rhps_pkg::HASH_BASE; mc_in = '0;
            end
            rhps_pkg::MUL_SRC_REM: begin
               ma_in = tp_ff;  mm_in = old_digit;           mc_in = '0;
            end
            rhps_pkg::MUL_SRC_TEXT: begin
               ma_in = rh_ff;  mm_in = rhps_pkg::HASH_BASE; mc_in = digit;
            end
            rhps_pkg::MUL_SRC_ROLL: begin
               ma_in = roll_a; mm_in = rhps_pkg::HASH_BASE; mc_in = digit;
            end
            default: begin
               ma_in = '0;     mm_in = '0;                  mc_in = '0;
            end
         endcase
      end else if (cnt_ff != '0) begin
         acc_in = add_red[HW-1:0];
         mm_in  = {mm_ff[7:0], 1'b0};
         cnt_in = cnt_ff - 4'd1;
      end

      if (cmd.mul_finish) begin
         acc_in = fin_val;
         case (src_ff)
            rhps_pkg::MUL_SRC_PAT:  ph_in = fin_val;
            rhps_pkg::MUL_SRC_POW:  tp_in = fin_val;
            rhps_pkg::MUL_SRC_TEXT: rh_in = fin_val;
            rhps_pkg::MUL_SRC_ROLL: rh_in = fin_val;
            default: ;
         endcase
      end

      if (cmd.commit) begin
         ptr_in   = ptr_next;
         count_in = count_next;
      end

      if (cmd.ver_start) begin
         vissue_in = '0;
         vring_in  = vstart;
         found_in  = 1'b1;
         pend_in   = 1'b0;
      end

      if (cmd.miss) begin
         found_in = 1'b0;
      end

      if (cmd.ver_step) begin
         if (vissue_ff < len_ff) begin
            vissue_in = vissue_ff + LW'(1);
            vring_in  = (vring_ff == AW'(PATTERN_MAX - 1)) ? '0 : vring_ff + AW'(1);
            pend_in   = 1'b1;
         end else begin
            pend_in   = 1'b0;
         end
         if (pend_ff && (ring_rdata != pat_rdata)) begin
            found_in = 1'b0;
         end
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         out_found_in = found_ff;
         out_pos_in   = count_ff - 32'(len_ff);
         out_hash_in  = rh_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LW'(1);
         ptr_ff       <= '0;
         count_ff     <= '0;
         ph_ff        <= '0;
         rh_ff        <= '0;
         tp_ff        <= HW'(1);
         cnt_ff       <= '0;
         vissue_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         ph_ff        <= ph_in;
         rh_ff        <= rh_in;
         tp_ff        <= tp_in;
         cnt_ff       <= cnt_in;
         vissue_ff    <= vissue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      idx_ff       <= idx_in;
      byte_ff      <= byte_in;
      src_ff       <= src_in;
      acc_ff       <= acc_in;
      ma_ff        <= ma_in;
      mm_ff        <= mm_in;
      mc_ff        <= mc_in;
      vring_ff     <= vring_in;
      found_ff     <= found_in;
      out_found_ff <= out_found_in;
      out_pos_ff   <= out_pos_in;
      out_hash_ff  <= out_hash_in;
   end

   rhps_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_pattern_ram (
      .clock (clock),
      .we    (cmd.pat_write),
      .waddr (idx_addr),
      .wdata (byte_ff),
      .raddr (pat_raddr),
      .rdata (pat_rdata)
   );

   rhps_ram #(.WIDTH(8), .DEPTH(PATTERN_MAX)) u_window_ram (
      .clock (clock),
      .we    (cmd.commit),
      .waddr (ptr_ff),
      .wdata (byte_ff),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   always_comb begin
      sts            = '0;
      sts.func       = func_ff;
      sts.idx_ok     = ({1'b0, idx_ff} < len_ff) && (int'(idx_ff) < PATTERN_MAX);
      sts.idx_zero   = (idx_ff == '0);
      sts.text_full  = (count_ff >= 32'(len_ff));
      sts.mul_ready  = (cnt_ff == '0);
      sts.now_full   = (count_next >= 32'(len_ff));
      sts.hash_equal = (rh_ff == ph_ff);
      sts.ver_done   = (vissue_ff == len_ff) && !pend_ff;
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_match_found    = out_found_ff;
   assign rsp_match_position = out_pos_ff;
   assign rsp_window_hash    = out_hash_ff;

endmodule

@@ rtl/rolling_hash_pattern_search.sv @@
// ----------------------------------------------------------------------------
// rolling_hash_pattern_search
// Rabin-Karp search of a byte stream against a loaded pattern.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; req_stall is high from the cycle after
// acceptance until the sequencer is back in idle. Timing is set by the shared
// bit-serial modular multiplier (9 steps plus one finishing add per product):
// a pattern byte at index 0 and a start transaction skip the multiplier, a
// later pattern byte takes two products, a text byte while the window fills
// one (the byte that fills it goes on to the result hand-off), and a text
// byte on a full window two. A hash hit adds a byte-by-byte verification walk
// through the pattern and window RAMs. The result register lets the next
// transaction in while a result waits on rsp_stall; the sequencer only holds
// if a second result is ready before the first has been taken. Write csr_wdata
// (clamped to 1..PATTERN_MAX) only while the block is idle.
// ----------------------------------------------------------------------------
module rolling_hash_pattern_search #(
   parameter int PATTERN_MAX = rhps_pkg::PATTERN_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input transactions
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [5:0]  req_index,
   input  logic [7:0]  req_byte_value,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_match_found,
   output logic [31:0] rsp_match_position,
   output logic [29:0] rsp_window_hash,
   // pattern length register
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);

   rhps_pkg::rhps_cmd_type cmd;
   rhps_pkg::rhps_sts_type sts;

   // sequencer
   rhps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hash arithmetic, storage and result register
   rhps_dp #(.PATTERN_MAX(PATTERN_MAX)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_index          (req_index),
      .req_byte_value     (req_byte_value),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_match_found    (rsp_match_found),
      .rsp_match_position (rsp_match_position),
      .rsp_window_hash    (rsp_window_hash)
   );

   // busy straight after an accepted transaction
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("accepted transaction did not make the block busy");

   // a reported hash is always fully reduced
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_window_hash < rhps_pkg::HASH_MOD))
      else $error("window hash not reduced");

   // a hand-off always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result lost at hand-off");

   // multiplier is never restarted while the verification walk runs
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.mul_start && cmd.ver_step))
      else $error("multiplier started during verification");

endmodule
